// ===== rtl/persistent_tree_range_kth_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef PERSISTENT_TREE_RANGE_KTH_UNIT_MACROS_SVH
`define PERSISTENT_TREE_RANGE_KTH_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PTRK_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PTRK_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/ptrk_pkg.sv =====
// Package with types, constants and helpers for the range k-th unit.
`default_nettype none
package ptrk_pkg;
    localparam int MAX_ELEMENTS = 1024;
    localparam int POOL_DEPTH   = 11265;
    localparam int NODE_AW      = $clog2(POOL_DEPTH);
    localparam int VER_AW       = $clog2(MAX_ELEMENTS + 1);
    localparam int CNT_W        = 11;
    localparam int RANK_W       = 11;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_RANGE = 3'd1;
    localparam logic [2:0] ST_BAD_K     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_RANK  = 3'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic [10:0]        left_pos;
        logic [10:0]        right_pos;
        logic [10:0]        order_or_rank;
        logic signed [31:0] elem_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [10:0]        found_rank;
        logic signed [31:0] found_value;
        logic [10:0]        version_count;
    } out_item_t;

    typedef struct packed {
        logic [NODE_AW-1:0] lch;
        logic [NODE_AW-1:0] rch;
        logic [CNT_W-1:0]   cnt;
    } node_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_A_ROOT, S_A_RD, S_A_WR, S_A_DONE,
        S_Q_ROOT1, S_Q_ROOT2, S_Q_RDY, S_Q_RDX, S_Q_LCY, S_Q_LCX, S_Q_STEP,
        S_Q_VAL, S_OUT
    } state_t;

    // Commands from the sequencer to the node datapath.
    typedef struct packed {
        logic               rd_en;
        logic [NODE_AW-1:0] rd_addr;
        logic               wr_en;
        logic [NODE_AW-1:0] wr_addr;
        node_t              wr_data;
    } node_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/ptrk_node_mem.sv =====
// Node pool memory: one write port, one registered read port, null node at zero.
`default_nettype none
module ptrk_node_mem (
    input  wire logic              aclk,
    input  wire ptrk_pkg::node_cmd_t cmd,
    output ptrk_pkg::node_t        rd_data
);
    ptrk_pkg::node_t mem [ptrk_pkg::POOL_DEPTH];
    ptrk_pkg::node_t raw_reg;
    logic            null_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en) begin
            raw_reg  <= mem[cmd.rd_addr];
            null_reg <= (cmd.rd_addr == '0);
        end
    end

    // Node zero always reads as the all-zero null node.
    assign rd_data = null_reg ? '0 : raw_reg;
endmodule
`default_nettype wire

// ===== rtl/persistent_tree_range_kth_unit.sv =====
// Range k-th smallest unit: a persistent counting segment tree walked one level
// at a time. An append reads and rewrites one node per tree level; a query reads
// both version nodes and the left child of each at every level, then steps
// down; both are paced by the single read port of the node pool. The block takes
// one beat at a time; the result is held in an output register until taken, and
// s_ready stays low meanwhile.
`default_nettype none
module persistent_tree_range_kth_unit (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [10:0]          cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ptrk_pkg::in_item_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ptrk_pkg::out_item_t       m_data
);
    localparam int NA = ptrk_pkg::NODE_AW;
    localparam int VA = ptrk_pkg::VER_AW;

    ptrk_pkg::state_t    state_reg, state_next;
    ptrk_pkg::in_item_t  item_reg;
    ptrk_pkg::out_item_t out_reg, out_next;
    logic [10:0] uni_reg;
    logic [10:0] used_reg, used_next;
    logic [NA-1:0] free_reg, free_next;
    logic [10:0] lo_reg, lo_next, hi_reg, hi_next, k_reg, k_next;
    logic [NA-1:0] x_reg, x_next, y_reg, y_next, cur_reg, cur_next;
    logic [10:0] ycnt_reg, ycnt_next;
    logic [NA-1:0] xl_reg, xl_next, xr_reg, xr_next;
    logic [NA-1:0] yl_reg, yl_next, yr_reg, yr_next;
    logic [NA-1:0] root_rd_reg;
    logic          root_null_reg;
    logic [NA-1:0] root_rd;
    logic signed [31:0] val_rd_reg;
    ptrk_pkg::node_t nd;
    ptrk_pkg::node_cmd_t cmd;

    logic [NA-1:0] roots [ptrk_pkg::MAX_ELEMENTS + 1];
    logic signed [31:0] vals [1024];
    logic root_we, root_re, val_we, val_re;
    logic [VA-1:0] root_waddr, root_raddr;
    logic [9:0] val_addr;

    ptrk_node_mem u_mem (.aclk(aclk), .cmd(cmd), .rd_data(nd));

    // A new root is always the node allocated at the append's start.
    always_ff @(posedge aclk) begin
        if (root_we) roots[root_waddr] <= free_reg;
        if (root_re) begin
            root_rd_reg   <= roots[root_raddr];
            root_null_reg <= (root_raddr == '0);
        end
        if (val_we) vals[val_addr] <= item_reg.elem_value;
        if (val_re) val_rd_reg <= vals[val_addr];
    end

    // Version zero always points at the null node.
    assign root_rd = root_null_reg ? '0 : root_rd_reg;

    logic [10:0] eff_uni, mid, rank, diff;
    logic [11:0] len;
    logic [4:0]  depth;
    logic [NA:0] room;
    always_comb begin
        eff_uni = (uni_reg == '0) ? 11'd1 : (uni_reg > 11'd1024 ? 11'd1024 : uni_reg);
        mid     = 11'((12'(lo_reg) + 12'(hi_reg)) >> 1);
        rank    = item_reg.order_or_rank;
        diff    = ycnt_reg - nd.cnt;
        len     = 12'(item_reg.right_pos) - 12'(item_reg.left_pos) + 12'd1;
        // path length is at most ceil(log2(universe))+1 nodes
        depth   = 5'd1;
        for (int b = 1; b <= 10; b++) begin
            if ((eff_uni - 11'd1) >= (11'd1 << (b - 1))) depth = 5'(b + 1);
        end
        room    = (NA+1)'(ptrk_pkg::POOL_DEPTH) - {1'b0, free_reg};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ptrk_pkg::S_IDLE: if (s_valid && s_ready) begin
                case (s_data.op)
                    ptrk_pkg::OP_APPEND: state_next = ptrk_pkg::S_A_ROOT;
                    ptrk_pkg::OP_QUERY:  state_next = ptrk_pkg::S_Q_ROOT1;
                    default:             state_next = ptrk_pkg::S_CLEAR;
                endcase
            end
            ptrk_pkg::S_CLEAR:   state_next = ptrk_pkg::S_OUT;
            ptrk_pkg::S_A_ROOT: begin
                if (rank == '0 || rank > eff_uni || used_reg >= 11'(ptrk_pkg::MAX_ELEMENTS)
                    || free_reg >= NA'(ptrk_pkg::POOL_DEPTH)
                    || (NA+1)'(depth) > room)
                    state_next = ptrk_pkg::S_OUT;
                else
                    state_next = ptrk_pkg::S_A_RD;
            end
            ptrk_pkg::S_A_RD:    state_next = ptrk_pkg::S_A_WR;
            ptrk_pkg::S_A_WR:    state_next = (lo_reg >= hi_reg) ? ptrk_pkg::S_A_DONE
                                                                 : ptrk_pkg::S_A_RD;
            ptrk_pkg::S_A_DONE:  state_next = ptrk_pkg::S_OUT;
            ptrk_pkg::S_Q_ROOT1: begin
                if (item_reg.left_pos == '0 || item_reg.left_pos > item_reg.right_pos
                    || item_reg.right_pos > used_reg)
                    state_next = ptrk_pkg::S_OUT;
                else if (item_reg.order_or_rank == '0 || 12'(item_reg.order_or_rank) > len)
                    state_next = ptrk_pkg::S_OUT;
                else
                    state_next = ptrk_pkg::S_Q_ROOT2;
            end
            ptrk_pkg::S_Q_ROOT2: state_next = ptrk_pkg::S_Q_RDY;
            ptrk_pkg::S_Q_RDY:   state_next = (lo_reg >= hi_reg) ? ptrk_pkg::S_Q_VAL
                                                                 : ptrk_pkg::S_Q_RDX;
            ptrk_pkg::S_Q_RDX:   state_next = ptrk_pkg::S_Q_LCY;
            ptrk_pkg::S_Q_LCY:   state_next = ptrk_pkg::S_Q_LCX;
            ptrk_pkg::S_Q_LCX:   state_next = ptrk_pkg::S_Q_STEP;
            ptrk_pkg::S_Q_STEP:  state_next = ptrk_pkg::S_Q_RDY;
            ptrk_pkg::S_Q_VAL:   state_next = ptrk_pkg::S_OUT;
            ptrk_pkg::S_OUT:     if (m_ready) state_next = ptrk_pkg::S_IDLE;
            default:             state_next = ptrk_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        out_next = out_reg;
        used_next = used_reg; free_next = free_reg;
        lo_next = lo_reg; hi_next = hi_reg; k_next = k_reg;
        x_next = x_reg; y_next = y_reg; cur_next = cur_reg;
        ycnt_next = ycnt_reg;
        xl_next = xl_reg; xr_next = xr_reg; yl_next = yl_reg; yr_next = yr_reg;
        cmd = '0;
        root_we = 1'b0; root_re = 1'b0; val_we = 1'b0; val_re = 1'b0;
        root_waddr = VA'(used_reg) + VA'(1);
        root_raddr = VA'(used_reg);
        val_addr = 10'(rank - 11'd1);
        s_ready = (state_reg == ptrk_pkg::S_IDLE) && !cfg_we;
        m_valid = (state_reg == ptrk_pkg::S_OUT);
        case (state_reg)
            ptrk_pkg::S_IDLE: begin
                out_next = '0;
                lo_next = 11'd1; hi_next = eff_uni;
                k_next = s_data.order_or_rank;
                root_re = 1'b1;
                root_raddr = VA'(used_reg);
                if (s_data.op == ptrk_pkg::OP_QUERY)
                    root_raddr = (s_data.left_pos == '0) ? '0 : VA'(s_data.left_pos - 11'd1);
            end
            ptrk_pkg::S_CLEAR: begin
                if (item_reg.op == ptrk_pkg::OP_CLEAR) begin
                    used_next = '0; free_next = NA'(1);
                end
                out_next.version_count = (item_reg.op == ptrk_pkg::OP_CLEAR) ? '0 : used_reg;
            end
            ptrk_pkg::S_A_ROOT: begin
                x_next = root_rd;
                cur_next = free_reg;
                out_next.version_count = used_reg;
                if (rank == '0 || rank > eff_uni)
                    out_next.status = ptrk_pkg::ST_BAD_RANK;
                else if (used_reg >= 11'(ptrk_pkg::MAX_ELEMENTS)
                         || free_reg >= NA'(ptrk_pkg::POOL_DEPTH) || (NA+1)'(depth) > room)
                    out_next.status = ptrk_pkg::ST_FULL;
                else begin
                    root_we = 1'b1;
                    root_waddr = VA'(used_reg) + VA'(1);
                    free_next = free_reg + NA'(1);
                end
            end
            ptrk_pkg::S_A_RD: begin
                cmd.rd_en = 1'b1; cmd.rd_addr = x_reg;
            end
            ptrk_pkg::S_A_WR: begin
                cmd.wr_en = 1'b1; cmd.wr_addr = cur_reg;
                cmd.wr_data = nd;
                cmd.wr_data.cnt = nd.cnt + 11'd1;
                if (lo_reg < hi_reg) begin
                    cur_next = free_reg;
                    free_next = free_reg + NA'(1);
                    if (rank <= mid) begin
                        cmd.wr_data.lch = free_reg; x_next = nd.lch; hi_next = mid;
                    end else begin
                        cmd.wr_data.rch = free_reg; x_next = nd.rch; lo_next = mid + 11'd1;
                    end
                end
            end
            ptrk_pkg::S_A_DONE: begin
                val_we = 1'b1;
                used_next = used_reg + 11'd1;
                out_next.version_count = used_reg + 11'd1;
            end
            ptrk_pkg::S_Q_ROOT1: begin
                x_next = root_rd;
                root_re = 1'b1; root_raddr = VA'(item_reg.right_pos);
                out_next.version_count = used_reg;
                if (item_reg.left_pos == '0 || item_reg.left_pos > item_reg.right_pos
                    || item_reg.right_pos > used_reg)
                    out_next.status = ptrk_pkg::ST_BAD_RANGE;
                else if (item_reg.order_or_rank == '0 || 12'(item_reg.order_or_rank) > len)
                    out_next.status = ptrk_pkg::ST_BAD_K;
            end
            ptrk_pkg::S_Q_ROOT2: y_next = root_rd;
            ptrk_pkg::S_Q_RDY: begin
                cmd.rd_en = 1'b1; cmd.rd_addr = y_reg;
                val_re = 1'b1; val_addr = 10'(lo_reg - 11'd1);
            end
            ptrk_pkg::S_Q_RDX: begin
                yl_next = nd.lch; yr_next = nd.rch;
                cmd.rd_en = 1'b1; cmd.rd_addr = x_reg;
            end
            ptrk_pkg::S_Q_LCY: begin
                xl_next = nd.lch; xr_next = nd.rch;
                cmd.rd_en = 1'b1; cmd.rd_addr = yl_reg;
            end
            ptrk_pkg::S_Q_LCX: begin
                ycnt_next = nd.cnt;
                cmd.rd_en = 1'b1; cmd.rd_addr = xl_reg;
            end
            ptrk_pkg::S_Q_STEP: begin
                // descend both versions together
                if (diff >= k_reg) begin
                    x_next = xl_reg; y_next = yl_reg; hi_next = mid;
                end else begin
                    k_next = k_reg - diff;
                    x_next = xr_reg; y_next = yr_reg; lo_next = mid + 11'd1;
                end
            end
            ptrk_pkg::S_Q_VAL: begin
                out_next.found_rank = lo_reg;
                out_next.found_value = val_rd_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ptrk_pkg::S_IDLE;
            uni_reg <= 11'd1024;
            used_reg <= '0;
            free_reg <= NA'(1);
        end else if (cfg_we) begin
            uni_reg <= cfg_wdata;
            used_reg <= '0;
            free_reg <= NA'(1);
            state_reg <= state_next;
        end else begin
            state_reg <= state_next;
            used_reg <= used_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) item_reg <= s_data;
        out_reg <= out_next;
        lo_reg <= lo_next; hi_reg <= hi_next; k_reg <= k_next;
        x_reg <= x_next; y_reg <= y_next; cur_reg <= cur_next;
        ycnt_reg <= ycnt_next;
        xl_reg <= xl_next; xr_reg <= xr_next; yl_reg <= yl_next; yr_reg <= yr_next;
    end

    assign m_data = out_reg;
endmodule
`default_nettype wire

// ===== rtl/ptrk_checker.sv =====
// Port-level checker for the range k-th unit, bound to the top level.
`default_nettype none
`include "persistent_tree_range_kth_unit_macros.svh"
module ptrk_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire ptrk_pkg::out_item_t m_data
);
    `PTRK_ASSERT_IMPL(a_one_side, aclk, aresetn, m_valid, !s_ready)
    `PTRK_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `PTRK_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `PTRK_ASSERT_IMPL(a_status_code, aclk, aresetn, m_valid, m_data.status <= ptrk_pkg::ST_BAD_RANK)
    `PTRK_ASSERT_IMPL(a_fail_zero, aclk, aresetn, m_valid && m_data.status != ptrk_pkg::ST_OK,
        m_data.found_rank == '0)
endmodule

bind persistent_tree_range_kth_unit ptrk_checker u_ptrk_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
`default_nettype wire
